// File: rtl/core/psched_pkg.sv
package psched_pkg;

  // Table size and derived widths
  localparam int MAX_TASKS = 16;
  localparam int ID_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TIME_W    = 16;
  localparam int PRIO_W    = 8;
  localparam int TASK_ID_W = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Command codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_TURN,
    ST_WAIT,
    ST_EMIT
  } sched_state_t;

  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] task_arrival;
    logic [TIME_W-1:0] task_burst;
    logic [PRIO_W-1:0] task_priority;
  } sched_cmd_t;

  typedef struct packed {
    logic                 load_rejected;
    logic                 idle;
    logic [TASK_ID_W-1:0] running_task;
    logic                 task_finished;
    logic [TIME_W-1:0]    completion_time;
    logic [TIME_W-1:0]    turnaround_time;
    logic [TIME_W-1:0]    waiting_time;
    logic                 all_done;
  } sched_rsp_t;

  // One row of the task table
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
    logic [PRIO_W-1:0] prio;
  } task_row_t;

endpackage

// File: rtl/core/psched_task_ram.sv
module psched_task_ram
  import psched_pkg::*;
(
  input  logic            clk,
  input  logic            wr_en,
  input  logic [ID_W-1:0] wr_addr,
  input  task_row_t       wr_data,
  input  logic            rd_en,
  input  logic [ID_W-1:0] rd_addr,
  output task_row_t       rd_data
);

  task_row_t mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/preemptive_priority_scheduler_core.sv
// Preemptive priority scheduler. A load command (mode 0) stores a task's arrival,
// burst and priority under the next free id and answers with that id, or with
// load_rejected when the table is full or the burst is zero. A tick command
// (mode 1) readies tasks whose arrival equals the time counter, runs the ready
// task of highest priority (larger id on a tie) for one unit and reports it,
// with completion, turnaround and waiting times when it finishes; a tick with
// nothing ready reports idle. Every command gives exactly one response. The task
// table sits in a single-port-read synchronous RAM; a tick streams the loaded
// rows through the read port one per cycle. No clearing pass is needed after
// reset. A finished response waits in the output register while the next
// command is taken.
module preemptive_priority_scheduler_core
  import psched_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  sched_cmd_t cmd,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output sched_rsp_t rsp
);

  sched_state_t state, state_next;

  logic [TIME_W-1:0] time_cnt;
  logic [CNT_W-1:0]  loaded_cnt;
  logic [CNT_W-1:0]  completed_cnt;
  logic [MAX_TASKS-1:0] ready;

  // scan pipeline
  logic [CNT_W-1:0] scan_cnt;
  logic             rd_pend;
  logic [ID_W-1:0]  rd_idx;

  // winner of the scan
  logic             found;
  logic [ID_W-1:0]  best_idx;
  task_row_t        best_row;

  // finish arithmetic, one subtract per stage
  logic              fin;
  logic [TIME_W-1:0] comp_time;
  logic [TIME_W-1:0] tat;

  sched_rsp_t res;
  sched_rsp_t rsp_next;

  // RAM ports
  logic            wr_en;
  logic [ID_W-1:0] wr_addr;
  task_row_t       wr_data;
  logic            rd_en;
  logic [ID_W-1:0] rd_addr;
  task_row_t       rd_data;

  logic cmd_xfer;
  logic load_ok;
  logic scan_more;
  logic hit;
  logic emit_fire;
  logic [TIME_W-1:0] rem_dec;

  psched_task_ram u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cmd_xfer  = cmd_valid && !cmd_stall;
  assign load_ok   = (loaded_cnt < CNT_W'(MAX_TASKS)) && (cmd.task_burst != '0);
  assign scan_more = scan_cnt < loaded_cnt;
  // a row counts as ready if already flagged or arriving on this tick
  assign hit       = ready[rd_idx] ||
                     ((rd_data.arrival == time_cnt) && (rd_data.remaining != '0));
  assign rem_dec   = best_row.remaining - TIME_W'(1);
  // output slot free: empty, or its response leaves at this edge
  assign emit_fire = (state == ST_EMIT) && (!rsp_valid || !rsp_stall);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_xfer) begin
          state_next = (cmd.mode == MODE_TICK) ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        // done once every row has been issued and the last one processed
        if (!scan_more && !rd_pend) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_TURN;
      ST_TURN:   state_next = ST_WAIT;
      ST_WAIT:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs and RAM access. Reads happen only in SCAN and writes only
  // in IDLE (load) or UPDATE, so a read never overlaps a write to the same row.
  always_comb begin
    cmd_stall = 1'b1;
    rd_en     = 1'b0;
    rd_addr   = scan_cnt[ID_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = loaded_cnt[ID_W-1:0];
    wr_data   = '{arrival:   cmd.task_arrival,
                  burst:     cmd.task_burst,
                  remaining: cmd.task_burst,
                  prio:      cmd.task_priority};
    case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        wr_en     = cmd_valid && (cmd.mode == MODE_LOAD) && load_ok;
      end
      ST_SCAN: begin
        rd_en = scan_more;
      end
      ST_UPDATE: begin
        wr_en   = found;
        wr_addr = best_idx;
        wr_data = '{arrival:   best_row.arrival,
                    burst:     best_row.burst,
                    remaining: rem_dec,
                    prio:      best_row.prio};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scheduler state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      time_cnt      <= '0;
      loaded_cnt    <= '0;
      completed_cnt <= '0;
      ready         <= '0;
      rd_pend       <= 1'b0;
      found         <= 1'b0;
      fin           <= 1'b0;
      scan_cnt      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_xfer) begin
            scan_cnt <= '0;
            rd_pend  <= 1'b0;
            found    <= 1'b0;
            fin      <= 1'b0;
            if (cmd.mode == MODE_LOAD) begin
              res <= '{load_rejected:   !load_ok,
                       idle:            1'b0,
                       running_task:    load_ok ? TASK_ID_W'(loaded_cnt[ID_W-1:0])
                                                : TASK_ID_W'(0),
                       task_finished:   1'b0,
                       completion_time: '0,
                       turnaround_time: '0,
                       waiting_time:    '0,
                       all_done:        1'b0};
              if (load_ok) begin
                ready[loaded_cnt[ID_W-1:0]] <= 1'b0;
                loaded_cnt                  <= loaded_cnt + CNT_W'(1);
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_more) begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
          rd_pend <= scan_more;
          rd_idx  <= rd_addr;
          if (rd_pend && hit) begin
            ready[rd_idx] <= 1'b1;
            // >= lets the later (larger) id win a priority tie
            if (!found || (rd_data.prio >= best_row.prio)) begin
              found    <= 1'b1;
              best_idx <= rd_idx;
              best_row <= rd_data;
            end
          end
        end
        ST_UPDATE: begin
          comp_time <= (time_cnt == TIME_MAX) ? time_cnt : time_cnt + TIME_W'(1);
          if (time_cnt != TIME_MAX) begin
            time_cnt <= time_cnt + TIME_W'(1);
          end
          if (found && (rem_dec == '0)) begin
            fin             <= 1'b1;
            ready[best_idx] <= 1'b0;
            completed_cnt   <= completed_cnt + CNT_W'(1);
          end
        end
        ST_TURN: begin
          tat <= (comp_time >= best_row.arrival) ? comp_time - best_row.arrival : '0;
        end
        ST_WAIT: begin
          res <= '{load_rejected:   1'b0,
                   idle:            !found,
                   running_task:    found ? TASK_ID_W'(best_idx) : TASK_ID_W'(0),
                   task_finished:   fin,
                   completion_time: fin ? comp_time : TIME_W'(0),
                   turnaround_time: fin ? tat : TIME_W'(0),
                   waiting_time:    (fin && (tat >= best_row.burst)) ? tat - best_row.burst
                                                                     : TIME_W'(0),
                   all_done:        1'b0};
        end
        default: begin
        end
      endcase
    end
  end

  // all_done reflects the counters after this command
  always_comb begin
    rsp_next          = res;
    rsp_next.all_done = (completed_cnt == loaded_cnt);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      rsp <= rsp_next;
    end
  end

endmodule
